@@ sv/bibd_pkg.sv @@
// Shared types, constants and helper functions for the brick decomposer.
package bibd_pkg;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLS    = 256;
    localparam int STACK_DEPTH = 18;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int SUM_W   = $clog2(MAX_ROWS * MAX_COLS + 1);
    localparam int DIM_W   = 9;
    localparam int STK_IW  = $clog2(STACK_DEPTH);
    localparam int STK_CW  = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_STEP = 2'd1;
    localparam logic [1:0] REQ_NEW  = 2'd2;

    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [COL_W-1:0] col_t;

    typedef struct packed {
        row_t top;
        col_t left;
        row_t bottom;
        col_t right;
    } rect_t;

    // Out-of-range dimension writes: zero becomes one, larger values saturate.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        begin
            if (v == '0)
                res = DIM_W'(1);
            else if (v > maxv)
                res = maxv;
            else
                res = v;
            return res;
        end
    endfunction

endpackage

@@ sv/bibd_sat_ram.sv @@
// Single-port synchronous RAM with a registered read, used for the table and the row lengths.
module bibd_sat_ram #(
    parameter int AW = 16,
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    // Write, or registered read, one access per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ sv/binary_image_brick_decomposer.sv @@
// Top level of the binary image brick decomposer.
// A load item passes through accept, upper read, diagonal read and write,
// since the summed-area table sits in one single-port RAM with a registered
// read. A small row-length RAM, read alongside it at the same row, records how
// many columns of each finished row were loaded for the current image, so the
// table is never swept when a new image starts; entries that were not loaded for
// this image read as zero. A step item pops the stack and stops there when it
// is empty; otherwise it drops a unit cell, splits a larger rectangle, or reads
// the four corners of a brick-sized candidate and then emits it or splits it,
// since the count needs four corner reads through the same RAM port. Loads and
// new images are accepted while a result waits; a step holds in its initial
// state until the previous result has been taken.
module binary_image_brick_decomposer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           req_type,
    input  logic                 pixel,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 brick_valid,
    output logic [7:0]           top_row,
    output logic [7:0]           left_col,
    output logic [7:0]           bottom_row,
    output logic [7:0]           right_col,
    output logic [15:0]          brick_id,
    output logic                 done_res,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [8:0]           cfg_data
);
    import bibd_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_LD_A  = 14'b00000000000010,
        S_LD_B  = 14'b00000000000100,
        S_LD_C  = 14'b00000000001000,
        S_INIT  = 14'b00000000010000,
        S_POP   = 14'b00000000100000,
        S_CLASS = 14'b00000001000000,
        S_RD0   = 14'b00000010000000,
        S_RD1   = 14'b00000100000000,
        S_RD2   = 14'b00001000000000,
        S_RD3   = 14'b00010000000000,
        S_RD4   = 14'b00100000000000,
        S_PUSH1 = 14'b01000000000000,
        S_PUSH2 = 14'b10000000000000
    } state_t;

    localparam logic [DIM_W-1:0] MAXR = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] MAXC = DIM_W'(MAX_COLS);

    state_t state_reg, state_next;

    logic [DIM_W-1:0] rows_reg, cols_reg;
    logic [DIM_W-1:0] lrow_reg, lrow_next;
    col_t             lcol_reg, lcol_next;
    rect_t            box_reg, box_next;
    logic             any_reg, any_next;
    logic             started_reg, started_next;
    logic [STK_CW-1:0] cnt_reg, cnt_next;
    logic [15:0]      bcnt_reg, bcnt_next;
    rect_t            cur_reg, cur_next;
    logic             pix_reg, pix_next;
    logic [SUM_W-1:0] up_reg, up_next;
    logic [SUM_W-1:0] left_reg, left_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic             ok_reg, ok_next;
    logic             chk_reg, chk_next;
    col_t             rcol_reg, rcol_next;

    rect_t            stack [STACK_DEPTH];
    logic             push_en;
    rect_t            push_rect;

    logic             ov_reg, ov_next;
    logic             obv_reg, obv_next;
    rect_t            orect_reg, orect_next;
    logic [15:0]      oid_reg, oid_next;
    logic             odone_reg, odone_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [SUM_W-1:0]    ram_wdata, ram_rdata, rd_val;

    logic                len_we;
    logic [DIM_W-1:0]    len_wdata, len_rdata;

    logic             accept;
    logic [DIM_W-1:0] h, w, lo, hi;
    logic             is_unit, is_brick, emit;
    logic [DIM_W-1:0] mid_r, mid_c;
    row_t             tm1;
    col_t             lm1;

    bibd_sat_ram #(.AW(ADDR_W), .DW(SUM_W)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Loaded length of each finished row, read at the same row as the table.
    bibd_sat_ram #(.AW(ROW_W), .DW(DIM_W)) u_len (
        .clk   (clk),
        .we    (len_we),
        .addr  (ram_addr[ADDR_W-1:COL_W]),
        .wdata (len_wdata),
        .rdata (len_rdata)
    );

    // Entry lies in a finished row, or in the current row before the load position.
    function automatic logic filled(input row_t r, input col_t c,
                                    input logic [DIM_W-1:0] lr, input col_t lc);
        begin
            return (DIM_W'(r) < lr) || ((DIM_W'(r) == lr) && (c < lc));
        end
    endfunction

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rd_val    = (ok_reg && (!chk_reg || (DIM_W'(rcol_reg) < len_rdata))) ?
                       ram_rdata : '0;

    // Shape of the current rectangle and its split points.
    always_comb
    begin
        h        = DIM_W'(cur_reg.bottom) - DIM_W'(cur_reg.top) + DIM_W'(1);
        w        = DIM_W'(cur_reg.right) - DIM_W'(cur_reg.left) + DIM_W'(1);
        lo       = (h < w) ? h : w;
        hi       = (h < w) ? w : h;
        is_unit  = (h == DIM_W'(1)) && (w == DIM_W'(1));
        is_brick = ((lo == DIM_W'(1)) || (lo == DIM_W'(2))) &&
                   (hi >= DIM_W'(2)) && (hi <= DIM_W'(4));
        mid_r    = (DIM_W'(cur_reg.top) + DIM_W'(cur_reg.bottom)) >> 1;
        mid_c    = (DIM_W'(cur_reg.left) + DIM_W'(cur_reg.right)) >> 1;
        tm1      = cur_reg.top - row_t'(1);
        lm1      = cur_reg.left - col_t'(1);
    end

    // Sequencer for loads and decomposition steps.
    always_comb
    begin
        state_next   = state_reg;
        lrow_next    = lrow_reg;
        lcol_next    = lcol_reg;
        box_next     = box_reg;
        any_next     = any_reg;
        started_next = started_reg;
        cnt_next     = cnt_reg;
        bcnt_next    = bcnt_reg;
        cur_next     = cur_reg;
        pix_next     = pix_reg;
        up_next      = up_reg;
        left_next    = left_reg;
        acc_next     = acc_reg;
        ok_next      = ok_reg;
        chk_next     = chk_reg;
        rcol_next    = rcol_reg;
        ov_next      = ov_reg && out_stall;
        obv_next     = obv_reg;
        orect_next   = orect_reg;
        oid_next     = oid_reg;
        odone_next   = odone_reg;
        ram_we       = 1'b0;
        ram_addr     = {lrow_reg[ROW_W-1:0] - row_t'(1), lcol_reg};
        ram_wdata    = '0;
        len_we       = 1'b0;
        len_wdata    = DIM_W'(lcol_reg) + DIM_W'(1);
        push_en      = 1'b0;
        push_rect    = cur_reg;
        emit         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_LOAD:
                        begin
                            if ((lrow_reg < rows_reg) && (DIM_W'(lcol_reg) < cols_reg))
                            begin
                                pix_next   = pixel;
                                state_next = S_LD_A;
                            end
                        end
                        REQ_STEP:
                        begin
                            state_next = S_INIT;
                        end
                        REQ_NEW:
                        begin
                            lrow_next    = '0;
                            lcol_next    = '0;
                            box_next     = '{top: '1, left: '1, bottom: '0, right: '0};
                            any_next     = 1'b0;
                            started_next = 1'b0;
                            cnt_next     = '0;
                            bcnt_next    = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // Upper neighbour read.
            S_LD_A:
            begin
                ram_addr   = {lrow_reg[ROW_W-1:0] - row_t'(1), lcol_reg};
                ok_next    = (lrow_reg != '0);
                chk_next   = 1'b1;
                rcol_next  = lcol_reg;
                state_next = S_LD_B;
            end
            // Diagonal neighbour read.
            S_LD_B:
            begin
                up_next    = rd_val;
                ram_addr   = {lrow_reg[ROW_W-1:0] - row_t'(1), lcol_reg - col_t'(1)};
                ok_next    = (lrow_reg != '0) && (lcol_reg != '0);
                chk_next   = 1'b1;
                rcol_next  = lcol_reg - col_t'(1);
                state_next = S_LD_C;
            end
            // Write the new sum, grow the box and advance the position.
            S_LD_C:
            begin
                ram_we    = 1'b1;
                ram_addr  = {lrow_reg[ROW_W-1:0], lcol_reg};
                ram_wdata = SUM_W'(pix_reg) + up_reg +
                            ((lcol_reg != '0) ? left_reg : '0) - rd_val;
                left_next = ram_wdata;
                if (pix_reg)
                begin
                    if (!any_reg || (lrow_reg[ROW_W-1:0] < box_reg.top))
                        box_next.top = lrow_reg[ROW_W-1:0];
                    if (!any_reg || (lcol_reg < box_reg.left))
                        box_next.left = lcol_reg;
                    if (!any_reg || (lrow_reg[ROW_W-1:0] > box_reg.bottom))
                        box_next.bottom = lrow_reg[ROW_W-1:0];
                    if (!any_reg || (lcol_reg > box_reg.right))
                        box_next.right = lcol_reg;
                    any_next = 1'b1;
                end
                if (DIM_W'(lcol_reg) + DIM_W'(1) >= cols_reg)
                begin
                    len_we    = 1'b1;
                    lcol_next = '0;
                    lrow_next = lrow_reg + DIM_W'(1);
                end
                else
                begin
                    lcol_next = lcol_reg + col_t'(1);
                end
                state_next = S_IDLE;
            end
            // The first step seeds the stack with the bounding box if any pixel is set; a step
            // waits here while the previous result is still unread.
            S_INIT:
            begin
                if (!ov_reg)
                begin
                    if (!started_reg)
                    begin
                        started_next = 1'b1;
                        if (any_reg && (cnt_reg < STK_CW'(STACK_DEPTH)))
                        begin
                            push_en   = 1'b1;
                            push_rect = box_reg;
                            cnt_next  = cnt_reg + STK_CW'(1);
                        end
                    end
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (cnt_reg == '0)
                begin
                    ov_next    = 1'b1;
                    obv_next   = 1'b0;
                    orect_next = '0;
                    oid_next   = '0;
                    odone_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next   = stack[STK_IW'(cnt_reg - STK_CW'(1))];
                    cnt_next   = cnt_reg - STK_CW'(1);
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (is_unit)
                begin
                    ov_next    = 1'b1;
                    obv_next   = 1'b0;
                    orect_next = '0;
                    oid_next   = '0;
                    odone_next = (cnt_reg == '0);
                    state_next = S_IDLE;
                end
                else if (is_brick)
                begin
                    state_next = S_RD0;
                end
                else
                begin
                    state_next = S_PUSH1;
                end
            end
            // Four corner reads, accumulated as they return.
            S_RD0:
            begin
                ram_addr   = {cur_reg.bottom, cur_reg.right};
                ok_next    = filled(cur_reg.bottom, cur_reg.right, lrow_reg, lcol_reg);
                chk_next   = (DIM_W'(cur_reg.bottom) < lrow_reg);
                rcol_next  = cur_reg.right;
                acc_next   = '0;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                acc_next   = acc_reg + rd_val;
                ram_addr   = {cur_reg.bottom, lm1};
                ok_next    = (cur_reg.left != '0) &&
                             filled(cur_reg.bottom, lm1, lrow_reg, lcol_reg);
                chk_next   = (DIM_W'(cur_reg.bottom) < lrow_reg);
                rcol_next  = lm1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                acc_next   = acc_reg - rd_val;
                ram_addr   = {tm1, cur_reg.right};
                ok_next    = (cur_reg.top != '0) &&
                             filled(tm1, cur_reg.right, lrow_reg, lcol_reg);
                chk_next   = (DIM_W'(tm1) < lrow_reg);
                rcol_next  = cur_reg.right;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                acc_next   = acc_reg - rd_val;
                ram_addr   = {tm1, lm1};
                ok_next    = (cur_reg.top != '0) && (cur_reg.left != '0) &&
                             filled(tm1, lm1, lrow_reg, lcol_reg);
                chk_next   = (DIM_W'(tm1) < lrow_reg);
                rcol_next  = lm1;
                state_next = S_RD4;
            end
            // Half-filled test, then emit or split.
            S_RD4:
            begin
                acc_next = acc_reg + rd_val;
                emit     = ({acc_next, 1'b0} >= (SUM_W + 1)'(h * w));
                if (emit)
                begin
                    bcnt_next  = bcnt_reg + 16'd1;
                    ov_next    = 1'b1;
                    obv_next   = 1'b1;
                    orect_next = cur_reg;
                    oid_next   = bcnt_next;
                    odone_next = (cnt_reg == '0);
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_PUSH1;
                end
            end
            // Second half goes on first so that the first half is examined next.
            S_PUSH1:
            begin
                if (w > h)
                    push_rect.left = col_t'(mid_c + DIM_W'(1));
                else
                    push_rect.top = row_t'(mid_r + DIM_W'(1));
                if (cnt_reg < STK_CW'(STACK_DEPTH))
                begin
                    push_en  = 1'b1;
                    cnt_next = cnt_reg + STK_CW'(1);
                end
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                if (w > h)
                    push_rect.right = col_t'(mid_c);
                else
                    push_rect.bottom = row_t'(mid_r);
                if (cnt_reg < STK_CW'(STACK_DEPTH))
                begin
                    push_en  = 1'b1;
                    cnt_next = cnt_reg + STK_CW'(1);
                end
                ov_next    = 1'b1;
                obv_next   = 1'b0;
                orect_next = '0;
                oid_next   = '0;
                odone_next = (cnt_next == '0);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rows_reg    <= MAXR;
            cols_reg    <= MAXC;
            lrow_reg    <= '0;
            lcol_reg    <= '0;
            box_reg     <= '{top: '1, left: '1, bottom: '0, right: '0};
            any_reg     <= 1'b0;
            started_reg <= 1'b0;
            cnt_reg     <= '0;
            bcnt_reg    <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lrow_reg    <= lrow_next;
            lcol_reg    <= lcol_next;
            box_reg     <= box_next;
            any_reg     <= any_next;
            started_reg <= started_next;
            cnt_reg     <= cnt_next;
            bcnt_reg    <= bcnt_next;
            ov_reg      <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROWS: rows_reg <= clamp_dim(cfg_data, MAXR);
                    CFG_COLS: cols_reg <= clamp_dim(cfg_data, MAXC);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers and the rectangle stack.
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        pix_reg   <= pix_next;
        up_reg    <= up_next;
        left_reg  <= left_next;
        acc_reg   <= acc_next;
        ok_reg    <= ok_next;
        chk_reg   <= chk_next;
        rcol_reg  <= rcol_next;
        obv_reg   <= obv_next;
        orect_reg <= orect_next;
        oid_reg   <= oid_next;
        odone_reg <= odone_next;
        if (push_en)
        begin
            stack[STK_IW'(cnt_reg)] <= push_rect;
        end
    end

    assign out_valid   = ov_reg;
    assign brick_valid = obv_reg;
    assign top_row     = orect_reg.top;
    assign left_col    = orect_reg.left;
    assign bottom_row  = orect_reg.bottom;
    assign right_col   = orect_reg.right;
    assign brick_id    = oid_reg;
    assign done_res    = odone_reg;

endmodule

@@ tb/bibd_checker.sv @@
// Checker for the brick decomposer: predicts every step result and compares it.
`timescale 1ns / 100ps

module bibd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic        pixel,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        brick_valid,
    input  logic [7:0]  top_row,
    input  logic [7:0]  left_col,
    input  logic [7:0]  bottom_row,
    input  logic [7:0]  right_col,
    input  logic [15:0] brick_id,
    input  logic        done_res,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          bricks_seen
);
    import bibd_pkg::*;

    typedef struct packed {
        logic        brick;
        logic [7:0]  top;
        logic [7:0]  left;
        logic [7:0]  bottom;
        logic [7:0]  right;
        logic [15:0] id;
        logic        finished;
    } step_res_t;

    // Predicted state of the block.
    int          area_sum [0:MAX_ROWS*MAX_COLS-1];
    int          rows_cfg;
    int          cols_cfg;
    int          next_row;
    int          next_col;
    int          box_top, box_left, box_bottom, box_right;
    bit          box_valid;
    rect_t       rect_pile [0:STACK_DEPTH-1];
    int          pile_depth;
    bit          decomposing;
    logic [15:0] brick_seq;

    step_res_t   step_results_due [$];

    function automatic int clamp_size(input logic [8:0] v, input int maxv);
        int res;
        if (v == 0)
            res = 1;
        else if (v > maxv)
            res = maxv;
        else
            res = v;
        return res;
    endfunction

    // Reads outside the table give zero.
    function automatic int sum_at(input int r, input int c);
        int res;
        if (r < 0 || c < 0 || r >= MAX_ROWS || c >= MAX_COLS)
            res = 0;
        else
            res = area_sum[r*MAX_COLS + c];
        return res;
    endfunction

    function automatic bit is_brick_size(input int a, input int b);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (lo == 1 || lo == 2) && hi >= 2 && hi <= 4;
    endfunction

    task automatic start_image();
        for (int i = 0; i < MAX_ROWS*MAX_COLS; i++)
            area_sum[i] = 0;
        next_row    = 0;
        next_col    = 0;
        box_valid   = 0;
        box_top     = 0;
        box_left    = 0;
        box_bottom  = 0;
        box_right   = 0;
        pile_depth  = 0;
        decomposing = 0;
        brick_seq   = '0;
    endtask

    task automatic pile_push(input int t, input int l, input int b, input int r);
        if (pile_depth < STACK_DEPTH)
        begin
            rect_pile[pile_depth].top    = row_t'(t);
            rect_pile[pile_depth].left   = col_t'(l);
            rect_pile[pile_depth].bottom = row_t'(b);
            rect_pile[pile_depth].right  = col_t'(r);
            pile_depth++;
        end
    endtask

    task automatic load_pixel(input logic pix);
        int r;
        int c;
        r = next_row;
        c = next_col;
        if (r < rows_cfg && c < cols_cfg)
        begin
            area_sum[r*MAX_COLS + c] = int'(pix) + sum_at(r - 1, c) + sum_at(r, c - 1)
                                       - sum_at(r - 1, c - 1);
            if (pix)
            begin
                if (!box_valid || r < box_top)    box_top = r;
                if (!box_valid || c < box_left)   box_left = c;
                if (!box_valid || r > box_bottom) box_bottom = r;
                if (!box_valid || c > box_right)  box_right = c;
                box_valid = 1;
            end
            if (c + 1 >= cols_cfg)
            begin
                next_col = 0;
                next_row = r + 1;
            end
            else
                next_col = c + 1;
        end
    endtask

    // One step: pop a rectangle, then emit it, drop it or split it.
    task automatic step_once();
        step_res_t res;
        rect_t     cur;
        int        h, w, cnt, mid, t, l, b, r;
        bit        emitted;
        res = '0;
        if (!decomposing)
        begin
            decomposing = 1;
            if (box_valid)
                pile_push(box_top, box_left, box_bottom, box_right);
        end
        if (pile_depth == 0)
            res.finished = 1;
        else
        begin
            pile_depth--;
            cur = rect_pile[pile_depth];
            t = cur.top;
            l = cur.left;
            b = cur.bottom;
            r = cur.right;
            h = b - t + 1;
            w = r - l + 1;
            if (!(h == 1 && w == 1))
            begin
                emitted = 0;
                if (is_brick_size(h, w))
                begin
                    cnt = sum_at(b, r) - sum_at(b, l - 1) - sum_at(t - 1, r)
                          + sum_at(t - 1, l - 1);
                    if (2 * cnt >= h * w)
                    begin
                        brick_seq  = brick_seq + 16'd1;
                        res.brick  = 1;
                        res.top    = 8'(t);
                        res.left   = 8'(l);
                        res.bottom = 8'(b);
                        res.right  = 8'(r);
                        res.id     = brick_seq;
                        emitted    = 1;
                    end
                end
                if (!emitted)
                begin
                    if (w > h)
                    begin
                        mid = (l + r) / 2;
                        pile_push(t, mid + 1, b, r);
                        pile_push(t, l, b, mid);
                    end
                    else
                    begin
                        mid = (t + b) / 2;
                        pile_push(mid + 1, l, b, r);
                        pile_push(t, l, mid, r);
                    end
                end
            end
            res.finished = (pile_depth == 0);
        end
        step_results_due = {step_results_due, res};
    endtask

    task automatic compare_result();
        step_res_t want;
        step_res_t got;
        got = {brick_valid, top_row, left_col, bottom_row, right_col, brick_id, done_res};
        results_seen++;
        if (brick_valid)
            bricks_seen++;
        if (step_results_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("Unexpected step result: ",
                         "brick=%0d (%0d,%0d)-(%0d,%0d) id=%0d done=%0d",
                         got.brick, got.top, got.left, got.bottom, got.right, got.id,
                         got.finished);
        end
        else
        begin
            want = step_results_due.pop_front();
            if (want != got)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Step result mismatch: expected ",
                             "brick=%0d (%0d,%0d)-(%0d,%0d) id=%0d done=%0d, ",
                             want.brick, want.top, want.left, want.bottom, want.right,
                             want.id, want.finished,
                             "got brick=%0d (%0d,%0d)-(%0d,%0d) id=%0d done=%0d",
                             got.brick, got.top, got.left, got.bottom, got.right,
                             got.id, got.finished);
            end
        end
    endtask

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        bricks_seen  = 0;
    end

    // Follow every handshake on the three channels.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rows_cfg = MAX_ROWS;
            cols_cfg = MAX_COLS;
            start_image();
            step_results_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                compare_result();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ROWS)
                    rows_cfg = clamp_size(cfg_data, MAX_ROWS);
                else if (cfg_index == CFG_COLS)
                    cols_cfg = clamp_size(cfg_data, MAX_COLS);
            end
            if (in_valid && !in_stall)
            begin
                if (req_type == REQ_LOAD)
                    load_pixel(pixel);
                else if (req_type == REQ_NEW)
                    start_image();
                else if (req_type == REQ_STEP)
                    step_once();
            end
        end
        pending = step_results_due.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top: clock, reset, stimulus, output back-pressure and the verdict.
`timescale 1ns / 100ps

module tb_top;
    import bibd_pkg::*;

    localparam int ITEM_TARGET = 1400;
    localparam int CYCLE_LIMIT = 800000;
    localparam logic [1:0] REQ_JUNK = 2'd3;
    localparam logic [1:0] CFG_JUNK = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic        pixel;
    logic        out_valid;
    logic        out_stall;
    logic        brick_valid;
    logic [7:0]  top_row;
    logic [7:0]  left_col;
    logic [7:0]  bottom_row;
    logic [7:0]  right_col;
    logic [15:0] brick_id;
    logic        done_res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;

    int fail_count;
    int pending;
    int results_seen;
    int bricks_seen;
    int items_sent;
    int images_run;
    int cycles;
    bit quiet;
    bit hold_wanted;

    binary_image_brick_decomposer dut (.*);

    bibd_checker checker_i (.*);

    initial
    begin
        clk = 0;
    end

    always #2 clk = ~clk;

    // Watchdog.
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[binary_image_brick_decomposer] ERROR");
            $finish;
        end
    end

    // Output side: random stall bursts, one long hold-off, none near the end.
    initial
    begin
        int  stall_left;
        bit  held_once;
        stall_left = 0;
        held_once  = 0;
        out_stall  = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (hold_wanted && !held_once)
            begin
                held_once  = 1;
                stall_left = 150;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 8);
            out_stall <= (stall_left > 0);
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic pix);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        pixel    <= pix;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [8:0] val, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // Wait until every step result is back and any load in flight has finished.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (16) @(posedge clk);
    endtask

    // One image: set its size, start it, load it, and step it if not abandoned.
    task automatic run_image(input logic [8:0] rows_raw, input logic [8:0] cols_raw,
                             input int density, input int steps, input bit abandon);
        int nr, nc, total;
        bit junk_reg;
        nr = (rows_raw == 0) ? 1 : ((rows_raw > MAX_ROWS) ? MAX_ROWS : rows_raw);
        nc = (cols_raw == 0) ? 1 : ((cols_raw > MAX_COLS) ? MAX_COLS : cols_raw);
        junk_reg = ($urandom_range(0, 3) == 0);
        settle();
        cfg_write(CFG_ROWS, rows_raw, 1'b0);
        cfg_write(CFG_COLS, cols_raw, !junk_reg);
        if (junk_reg)
            cfg_write(CFG_JUNK, 9'($urandom_range(0, 511)), 1'b1);
        send_item(REQ_NEW, 1'($urandom));
        images_run++;
        total = abandon ? (nr * nc) / 2 : nr * nc;
        for (int i = 0; i < total; i++)
            send_item(REQ_LOAD, ($urandom_range(0, 99) < density));
        if (abandon)
            return;
        // Occasional noise: loads past the end and unknown request codes.
        if ($urandom_range(0, 3) == 0)
            send_item(REQ_LOAD, 1'($urandom));
        if ($urandom_range(0, 3) == 0)
            send_item(REQ_JUNK, 1'($urandom));
        for (int i = 0; i < steps; i++)
        begin
            if (items_sent > 300)
                hold_wanted = 1;
            send_item(REQ_STEP, 1'($urandom));
        end
    endtask

    initial
    begin
        int big_left;
        int h, w, area;
        logic [8:0] rr, cc;
        rst_n       = 0;
        in_valid    = 0;
        req_type    = REQ_LOAD;
        pixel       = 0;
        cfg_valid   = 0;
        cfg_index   = CFG_ROWS;
        cfg_data    = '0;
        items_sent  = 0;
        images_run  = 0;
        quiet       = 0;
        hold_wanted = 0;
        big_left    = 4;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty image at reset size and an unknown request code.
        send_item(REQ_STEP, 1'b0);
        send_item(REQ_STEP, 1'b1);
        send_item(REQ_JUNK, 1'b1);

        // Directed: a full 2x3 image is one brick; a load past the end is ignored.
        run_image(9'd2, 9'd3, 100, 0, 1'b0);
        send_item(REQ_LOAD, 1'b1);
        repeat (3) send_item(REQ_STEP, 1'b0);

        // Directed: zero rows taken as one; a lone pixel is dropped.
        run_image(9'd0, 9'd1, 100, 2, 1'b0);

        // Directed: stepping starts after the first row, then loading goes on.
        settle();
        cfg_write(CFG_ROWS, 9'd2, 1'b0);
        cfg_write(CFG_COLS, 9'd4, 1'b1);
        send_item(REQ_NEW, 1'b0);
        send_item(REQ_LOAD, 1'b1);
        send_item(REQ_LOAD, 1'b0);
        send_item(REQ_LOAD, 1'b1);
        send_item(REQ_LOAD, 1'b1);
        send_item(REQ_STEP, 1'b0);
        repeat (4) send_item(REQ_LOAD, 1'b1);
        repeat (2) send_item(REQ_STEP, 1'b0);

        // Random images: mostly small, a few long strips at the size limits early on.
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent > ITEM_TARGET - 250)
                quiet = 1;
            if (big_left > 0 && items_sent < ITEM_TARGET / 2 &&
                $urandom_range(0, 12) == 0)
            begin
                case (big_left)
                    4:       begin rr = 9'd511; cc = 9'd1;   end
                    3:       begin rr = 9'd0;   cc = 9'd300; end
                    2:       begin rr = 9'd2;   cc = 9'd256; end
                    default: begin rr = 9'd256; cc = 9'd2;   end
                endcase
                big_left--;
                run_image(rr, cc, $urandom_range(20, 100), 120, 1'b0);
            end
            else
            begin
                h = $urandom_range(1, 8);
                w = $urandom_range(1, 8);
                area = h * w;
                run_image(9'(h), 9'(w), $urandom_range(0, 100),
                          2 * area + $urandom_range(0, 3), ($urandom_range(0, 9) == 0));
            end
        end

        settle();
        $display("Ran %0d items over %0d images; %0d step results checked, %0d of them bricks.",
                 items_sent, images_run, results_seen, bricks_seen);
        $display("Images were mostly up to 8x8, with loads past the end, unknown codes",
                 " and output back-pressure.");
        if (fail_count == 0)
            $display("[binary_image_brick_decomposer] OK");
        else
            $display("[binary_image_brick_decomposer] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/bibd_pkg.sv
sv/bibd_sat_ram.sv
sv/binary_image_brick_decomposer.sv
tb/bibd_checker.sv
tb/tb_top.sv
